[design/zwhd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// zwhd_pkg
// Shared types, constants and the sequency-ordered Hadamard sign function.
// ---------------------------------------------------------------------------
package zwhd_pkg;

	localparam int SIDE_MAX = 8;
	localparam int COEF_W   = 16;
	localparam int INTER_W  = 20;
	localparam int ACC2_W   = 24;
	localparam int QDEPTH   = 4;

	localparam logic CFG_BLOCK_LOG2 = 1'b0;
	localparam logic CFG_ZONE_LIMIT = 1'b1;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef;
		logic [2:0]               row;
		logic [2:0]               col;
		logic                     last;
	} coef_item_t;

	typedef struct packed {
		logic [1:0] side_log2;
		logic       clear;
	} back_ctl_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_P1,
		ST_P1D,
		ST_P2,
		ST_P2D,
		ST_EMIT
	} back_state_t;

	typedef logic signed [INTER_W-1:0] inter_t;
	typedef inter_t [SIDE_MAX-1:0] inter_vec_t;

	// Sign of H[seq][col] for side 2^l: 1 means -1.
	// Natural row = bit-reverse of the Gray code of the sequency index.
	function automatic logic h_neg(input logic [1:0] l, input logic [2:0] seq,
		input logic [2:0] col);
		logic [2:0] g;
		logic [2:0] nat;
		g   = seq ^ (seq >> 1);
		nat = 3'd0;
		for (int b = 0; b < 3; b++) begin
			if (b < int'(l))
				nat[b] = g[int'(l) - 1 - b];
		end
		return ^(nat & col);
	endfunction

endpackage
`default_nettype wire

[design/zwhd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// zwhd_front
// Holds configuration, tags each coefficient with its zonal position.
// ---------------------------------------------------------------------------
module zwhd_front #(
	parameter int MAX_BLOCK = 8
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire  signed [15:0]          coefficient,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire                         cfg_index,
	input  wire  [3:0]                  cfg_data,
	output logic                        push,
	output zwhd_pkg::coef_item_t        push_item,
	input  wire                         q_full,
	output zwhd_pkg::back_ctl_t         ctl
);
	import zwhd_pkg::*;

	localparam int MAX_LOG2 = $clog2(MAX_BLOCK + 1) - 1;

	logic [1:0] block_log2_q;
	logic [3:0] zone_q;
	logic [2:0] row_q;
	logic [2:0] col_q;
	logic [1:0] l;
	logic [3:0] n4;
	logic [3:0] z0;
	logic [3:0] z;
	logic [2:0] zm1;
	logic [3:0] sum;
	logic       last;
	logic       wr;

	always_comb begin
		l   = (int'(block_log2_q) > MAX_LOG2) ? 2'(MAX_LOG2) : block_log2_q;
		n4  = 4'd1 << l;
		z0  = (zone_q == 4'd0) ? 4'd1 : zone_q;
		z   = (z0 > n4) ? n4 : z0;
		zm1 = 3'(z - 4'd1);
		sum = {1'b0, row_q} + {1'b0, col_q} + 4'd1;
		last = (row_q == zm1);
	end

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;
	assign in_stall  = q_full;
	assign push      = in_valid && !q_full;

	assign push_item.coef = coefficient;
	assign push_item.row  = row_q;
	assign push_item.col  = col_q;
	assign push_item.last = last;

	assign ctl.side_log2 = l;
	assign ctl.clear     = wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_log2_q <= 2'd3;
			zone_q       <= 4'd8;
			row_q        <= 3'd0;
			col_q        <= 3'd0;
		end else if (wr) begin
			case (cfg_index)
				CFG_BLOCK_LOG2: block_log2_q <= cfg_data[1:0];
				CFG_ZONE_LIMIT: zone_q <= cfg_data;
				default: ;
			endcase
			row_q <= 3'd0;
			col_q <= 3'd0;
		end else if (push) begin
			if (last) begin
				row_q <= 3'd0;
				col_q <= 3'd0;
			end else if (sum < z) begin
				col_q <= col_q + 3'd1;
			end else begin
				row_q <= row_q + 3'd1;
				col_q <= 3'd0;
			end
		end
	end

endmodule
`default_nettype wire

[design/zwhd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// zwhd_queue
// Small FIFO of tagged coefficients between front and back.
// ---------------------------------------------------------------------------
module zwhd_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  zwhd_pkg::coef_item_t  push_item,
	output logic                  full,
	input  wire                   pop,
	output zwhd_pkg::coef_item_t  pop_item,
	output logic                  empty
);
	import zwhd_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	coef_item_t     mem_q [QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    cnt_q;

	assign full     = (cnt_q == (PW+1)'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

[design/zwhd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// zwhd_back
// Gathers a block, runs both Hadamard passes with lane accumulators, emits.
// ---------------------------------------------------------------------------
module zwhd_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  zwhd_pkg::back_ctl_t   ctl,
	input  wire                   q_empty,
	input  zwhd_pkg::coef_item_t  q_item,
	output logic                  pop,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic [7:0]            pixel,
	output logic [2:0]            pixel_row,
	output logic [2:0]            pixel_column,
	output logic                  last_pixel
);
	import zwhd_pkg::*;

	back_state_t state_q, state_d;
	logic [2:0] i_q, j_q, r_q, c_q;
	logic [2:0] i_s1, j_s1;
	logic       p1_vld_s1, p2_vld_s1;
	logic [2:0] nm1;
	logic [1:0] l;
	logic       out_load;

	logic signed [COEF_W-1:0] cs_mem [SIDE_MAX*SIDE_MAX];
	logic signed [COEF_W-1:0] cs_rd_s1;
	logic [SIDE_MAX*SIDE_MAX-1:0] vbits_q;
	logic       vb_s1;
	inter_vec_t im_mem [SIDE_MAX];
	inter_vec_t im_rd_s1;

	logic signed [INTER_W-1:0] acc1_q [SIDE_MAX];
	logic signed [INTER_W-1:0] acc1_d [SIDE_MAX];
	inter_vec_t                acc1_vec;
	logic signed [ACC2_W-1:0]  acc2_q [SIDE_MAX];
	logic signed [ACC2_W-1:0]  acc2_d [SIDE_MAX];
	logic signed [COEF_W-1:0]  term;
	logic signed [ACC2_W-1:0]  lane;
	logic [24:0] off;
	logic [24:0] v;
	logic [24:0] shifted;
	logic [7:0]  pix;

	assign l   = ctl.side_log2;
	assign nm1 = 3'((4'd1 << l) - 4'd1);

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_LOAD: begin
				pop = !q_empty;
				if (pop && q_item.last)
					state_d = ST_P1;
			end
			ST_P1: begin
				if (i_q == nm1 && j_q == nm1)
					state_d = ST_P1D;
			end
			ST_P1D: state_d = ST_P2;
			ST_P2: begin
				if (j_q == nm1)
					state_d = ST_P2D;
			end
			ST_P2D: state_d = ST_EMIT;
			ST_EMIT: begin
				out_load = !out_valid || !out_stall;
				if (out_load && c_q == nm1)
					state_d = (r_q == nm1) ? ST_LOAD : ST_P2;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			i_q       <= 3'd0;
			j_q       <= 3'd0;
			r_q       <= 3'd0;
			c_q       <= 3'd0;
			p1_vld_s1 <= 1'b0;
			p2_vld_s1 <= 1'b0;
			i_s1      <= 3'd0;
			j_s1      <= 3'd0;
			vbits_q   <= '0;
			vb_s1     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			p1_vld_s1 <= (state_q == ST_P1);
			p2_vld_s1 <= (state_q == ST_P2);
			i_s1      <= i_q;
			j_s1      <= j_q;
			vb_s1     <= vbits_q[{i_q, j_q}];
			case (state_q)
				ST_LOAD: begin
					i_q <= 3'd0;
					j_q <= 3'd0;
					r_q <= 3'd0;
					c_q <= 3'd0;
				end
				ST_P1: begin
					if (i_q == nm1) begin
						i_q <= 3'd0;
						j_q <= (j_q == nm1) ? 3'd0 : j_q + 3'd1;
					end else begin
						i_q <= i_q + 3'd1;
					end
				end
				ST_P2: j_q <= (j_q == nm1) ? 3'd0 : j_q + 3'd1;
				ST_EMIT: begin
					if (out_load) begin
						if (c_q == nm1) begin
							c_q <= 3'd0;
							r_q <= r_q + 3'd1;
						end else begin
							c_q <= c_q + 3'd1;
						end
					end
				end
				default: ;
			endcase
			// block store is dropped once pass one has read it
			if (ctl.clear || state_q == ST_P1D)
				vbits_q <= '0;
			else if (pop)
				vbits_q[{q_item.row, q_item.col}] <= 1'b1;
			if (out_load)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	// pass one: column j of H*B, one row of B per cycle across all lanes
	always_comb begin
		term = vb_s1 ? cs_rd_s1 : '0;
		for (int r = 0; r < SIDE_MAX; r++) begin
			acc1_d[r] = (i_s1 == 3'd0) ? '0 : acc1_q[r];
			if (h_neg(l, 3'(r), i_s1))
				acc1_d[r] = acc1_d[r] - INTER_W'(term);
			else
				acc1_d[r] = acc1_d[r] + INTER_W'(term);
			acc1_vec[r] = acc1_d[r];
		end
	end

	// pass two: row r of S, one intermediate term per cycle across all lanes
	always_comb begin
		lane = ACC2_W'($signed(im_rd_s1[r_q]));
		for (int c = 0; c < SIDE_MAX; c++) begin
			acc2_d[c] = (j_s1 == 3'd0) ? '0 : acc2_q[c];
			if (h_neg(l, 3'(c), j_s1))
				acc2_d[c] = acc2_d[c] - lane;
			else
				acc2_d[c] = acc2_d[c] + lane;
		end
	end

	// +128*n offset plus half for rounding; negative sums clamp to zero
	always_comb begin
		off     = (25'd128 << l) + ((25'd1 << l) >> 1);
		v       = 25'(acc2_q[c_q]) + off;
		shifted = v >> l;
		if (v[24])
			pix = 8'd0;
		else if (shifted > 25'd255)
			pix = 8'd255;
		else
			pix = shifted[7:0];
	end

	always_ff @(posedge clk) begin
		if (pop)
			cs_mem[{q_item.row, q_item.col}] <= q_item.coef;
		cs_rd_s1 <= cs_mem[{i_q, j_q}];
		im_rd_s1 <= im_mem[j_q];
		if (p1_vld_s1 && i_s1 == nm1)
			im_mem[j_s1] <= acc1_vec;
		if (p1_vld_s1)
			acc1_q <= acc1_d;
		if (p2_vld_s1)
			acc2_q <= acc2_d;
		if (out_load) begin
			pixel        <= pix;
			pixel_row    <= r_q;
			pixel_column <= c_q;
			last_pixel   <= (r_q == nm1) && (c_q == nm1);
		end
	end

endmodule
`default_nettype wire

[design/zonal_walsh_hadamard_block_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// After the last coefficient of a block leaves the queue, pass one runs over the
// block, then each pixel row runs its n sums, a drain step and its n emits, and
// the emits wait on out_stall; no new block is popped meanwhile. Coefficients
// enter at one per cycle while the 4-item queue is not full; the back end's passes
// set throughput. Reset restores block_log2=3, zone_limit=8 and an empty block.
// ---------------------------------------------------------------------------
// zonal_walsh_hadamard_block_decoder
// Zonal sequency-ordered inverse Walsh-Hadamard block decoder, top level.
// ---------------------------------------------------------------------------
module zonal_walsh_hadamard_block_decoder #(
	parameter int MAX_BLOCK = 8
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire signed [15:0] coefficient,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire               cfg_index,
	input  wire  [3:0]        cfg_data,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [7:0]        pixel,
	output logic [2:0]        pixel_row,
	output logic [2:0]        pixel_column,
	output logic              last_pixel
);
	import zwhd_pkg::*;

	logic       push;
	coef_item_t push_item;
	logic       q_full;
	logic       q_empty;
	logic       pop;
	coef_item_t pop_item;
	back_ctl_t  ctl;

	zwhd_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .coefficient(coefficient),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .push_item(push_item), .q_full(q_full), .ctl(ctl)
	);

	zwhd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_item(push_item), .full(q_full),
		.pop(pop), .pop_item(pop_item), .empty(q_empty)
	);

	zwhd_back u_back (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.q_empty(q_empty), .q_item(pop_item), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel(pixel), .pixel_row(pixel_row), .pixel_column(pixel_column),
		.last_pixel(last_pixel)
	);

endmodule
`default_nettype wire

[test/zonal_walsh_hadamard_block_decoder_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zonal_walsh_hadamard_block_decoder_tb
// Feeds zonal coefficient blocks under several block sizes and zone limits
// and checks every reconstructed pixel against a predicted inverse transform.
// ---------------------------------------------------------------------------
module zonal_walsh_hadamard_block_decoder_tb;
	import zwhd_pkg::*;

	typedef struct {
		int pix;
		int row;
		int col;
		int last;
	} pixel_exp_t;

	class pixel_scoreboard;
		int blog2;
		int zlim;
		int coef_grid[8][8];
		int coef_cnt;
		int errors;
		pixel_exp_t pending[$];

		function new();
			blog2 = 3;
			zlim = 8;
			errors = 0;
			clear_block();
		endfunction

		function void clear_block();
			foreach (coef_grid[i, j]) coef_grid[i][j] = 0;
			coef_cnt = 0;
		endfunction

		function void write_reg(logic idx, int d);
			if (idx == CFG_BLOCK_LOG2)
				blog2 = d & 3;
			else
				zlim = d & 15;
			clear_block();
		endfunction

		function int zone();
			int z;
			z = (zlim == 0) ? 1 : zlim;
			if (z > (1 << blog2))
				z = 1 << blog2;
			return z;
		endfunction

		function int block_len();
			return zone() * (zone() + 1) / 2;
		endfunction

		function void note_coefficient(logic signed [15:0] v);
			int n, z, k, changes, prev, sgn;
			int seq_h[8][8];
			int row_sign[8];
			int inter[8][8];
			longint s, q;
			pixel_exp_t e;
			n = 1 << blog2;
			z = zone();
			k = 0;
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++)
					if (i + j < z) begin
						if (k == coef_cnt)
							coef_grid[i][j] = v;
						k++;
					end
			coef_cnt = (coef_cnt + 1) & 63;
			if (coef_cnt < block_len())
				return;
			foreach (seq_h[i, j]) seq_h[i][j] = 0;
			// reorder natural Hadamard rows by sign-change count
			for (int i = 0; i < n; i++) begin
				changes = 0;
				prev = 1;
				for (int j = 0; j < n; j++) begin
					sgn = ($countones(i & j) & 1) ? -1 : 1;
					row_sign[j] = sgn;
					if (sgn != prev) begin
						changes++;
						prev = sgn;
					end
				end
				if (changes < n)
					for (int j = 0; j < n; j++) seq_h[changes][j] = row_sign[j];
			end
			for (int r = 0; r < n; r++)
				for (int j = 0; j < n; j++) begin
					inter[r][j] = 0;
					for (int i = 0; i < n; i++) inter[r][j] += seq_h[r][i] * coef_grid[i][j];
				end
			for (int r = 0; r < n; r++)
				for (int c = 0; c < n; c++) begin
					s = 128 * n;
					for (int j = 0; j < n; j++) s += longint'(inter[r][j]) * seq_h[c][j];
					if (s >= 0)
						q = (s + n / 2) >>> blog2;
					else
						q = -((-s + n / 2) >>> blog2);
					if (q < 0) q = 0;
					if (q > 255) q = 255;
					e.pix = int'(q);
					e.row = r;
					e.col = c;
					e.last = (r == n - 1 && c == n - 1);
					pending.push_back(e);
				end
			clear_block();
		endfunction

		function void check_pixel(int pix, int row, int col, int last);
			pixel_exp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected pixel %0d at (%0d,%0d)", $time, pix, row, col);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.pix != pix) begin
				$display("%0t: pixel exp %0d got %0d", $time, e.pix, pix);
				errors++;
			end
			if (e.row != row) begin
				$display("%0t: pixel_row exp %0d got %0d", $time, e.row, row);
				errors++;
			end
			if (e.col != col) begin
				$display("%0t: pixel_column exp %0d got %0d", $time, e.col, col);
				errors++;
			end
			if (e.last != last) begin
				$display("%0t: last_pixel exp %0d got %0d", $time, e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] coefficient;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [3:0] cfg_data;
	logic out_valid;
	logic out_stall;
	logic [7:0] pixel;
	logic [2:0] pixel_row;
	logic [2:0] pixel_column;
	logic last_pixel;

	pixel_scoreboard sb;
	int burst_left;
	int idle_cycles;
	int stall_mode;
	int cycle_cnt;

	zonal_walsh_hadamard_block_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.coefficient(coefficient),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel(pixel),
		.pixel_row(pixel_row),
		.pixel_column(pixel_column),
		.last_pixel(last_pixel)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: stall pattern switches between free-running, sparse and long stalls
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_pixel(pixel, pixel_row, pixel_column, last_pixel);
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt % 97 == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			default: out_stall <= ((cycle_cnt % 16) < 11);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_coef(logic signed [15:0] v);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		coefficient <= v;
		do @(posedge clk); while (in_stall);
		sb.note_coefficient(v);
	endtask

	task automatic write_reg(logic idx, logic [3:0] d);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, d);
	endtask

	task automatic set_mode(int bl, int zl);
		write_reg(CFG_BLOCK_LOG2, 4'(bl));
		write_reg(CFG_ZONE_LIMIT, 4'(zl));
	endtask

	function automatic logic signed [15:0] rand_coef();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'($urandom_range(0, 600) - 300);
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return 16'($urandom_range(0, 4000) - 2000);
		endcase
	endfunction

	initial begin
		int len;
		int sent;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		coefficient = '0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		out_stall = 1'b0;
		stall_mode = 0;
		cycle_cnt = 0;
		idle_cycles = 0;
		burst_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 1x1 block with zone limit zero: one coefficient per block, no rounding
		set_mode(0, 0);
		send_coef(16'sh7fff);
		send_coef(16'sh8000);
		send_coef(-16'sd128);
		send_coef(16'sd127);
		// 2x2, zone 2: rounding halves both signs, saturation both ends
		set_mode(1, 2);
		send_coef(16'sd1); send_coef(16'sd0); send_coef(16'sd0);
		send_coef(-16'sd257); send_coef(16'sd0); send_coef(16'sd0);
		send_coef(16'sh7fff); send_coef(16'sh8000); send_coef(16'sh7fff);
		send_coef(16'sh8000); send_coef(16'sh8000); send_coef(16'sh8000);
		// zone above side is capped; partial block then discarded by a write
		set_mode(2, 15);
		send_coef(16'sd5); send_coef(-16'sd3);
		set_mode(3, 1);
		send_coef(16'sd800);
		send_coef(-16'sd800);

		sent = 0;
		while (sent < 210) begin
			case ($urandom_range(0, 5))
				0: set_mode(3, 8);
				1: set_mode(0, $urandom_range(0, 15));
				default: set_mode($urandom_range(0, 3), $urandom_range(0, 15));
			endcase
			len = sb.block_len() * $urandom_range(1, 3);
			if (sb.block_len() > 1 && $urandom_range(0, 3) == 0)
				len += $urandom_range(1, sb.block_len() - 1);
			for (int k = 0; k < len && sent < 210; k++) begin
				send_coef(rand_coef());
				sent++;
			end
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

[filelist.f]
design/zwhd_pkg.sv
design/zwhd_front.sv
design/zwhd_queue.sv
design/zwhd_back.sv
design/zonal_walsh_hadamard_block_decoder.sv
test/zonal_walsh_hadamard_block_decoder_tb.sv
